@@ design/rrtss_pkg.sv @@
`default_nettype none

package rrtss_pkg;

    // Default size of the task slot table.
    localparam int unsigned MAX_TASKS_DEF = 64;

    // Time slice length after reset, in ticks.
    localparam logic [15:0] SLICE_RESET = 16'd1000;

    // Field widths of a request and of a result.
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SLOT_W   = 6;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned SLICE_W  = 16;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAULT  = 2'd2;

    // Register word index on the configuration port.
    localparam logic REG_SLICE = 1'b0;

    // Sequencer states.
    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_T_CUR,
        FSM_T_SCAN,
        FSM_A_SCAN,
        FSM_R_CHK
    } fsm_t;

endpackage

`default_nettype wire

@@ design/round_robin_task_slot_scheduler_unit.sv @@
`default_nettype none

// Round-robin task slot scheduler.
// Requests enter on start/cmd/target_slot and are taken when start is high
// and busy is low. Each request gives exactly one result on
// status/slot/switched, shown for one cycle with done high; the receiver
// cannot hold it off, so there is no stall to handle.
// The alive/dead flags sit in a simple dual-port synchronous memory with a
// registered read port; the slots-in-use count serves as its fill mark, so
// entries beyond it are never read and need no clearing after reset.
// Work per request:
//   tick that does not end a slice, unknown command, add on an empty
//   table: answered from idle; remove: one flag read, then the result;
//   add: flag scan from slot zero; tick that ends a slice: fault at once
//   if the current slot is out of range, else a read of its flag, then a
//   scan forward for the next live slot (a dead current slot faults).
// busy is high while the sequencer is out of idle, so a new request can be
// taken in the cycle that its predecessor's result is shown. The scans
// walk the flag memory one entry per cycle through its read port.
// Reset (rst_n low, asynchronous) empties the table, clears the current
// slot and tick counter, and sets slice_length to 1000.
// slice_length is written over the APB port at byte address 0.
module round_robin_task_slot_scheduler_unit #(
    parameter int unsigned MAX_TASKS = rrtss_pkg::MAX_TASKS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Request channel
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [rrtss_pkg::CMD_W-1:0]   cmd,
    input  wire logic [rrtss_pkg::SLOT_W-1:0]  target_slot,
    // Result channel
    output logic                               done,
    output logic [rrtss_pkg::STATUS_W-1:0]     status,
    output logic [rrtss_pkg::SLOT_W-1:0]       slot,
    output logic                               switched,
    // Configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import rrtss_pkg::*;

    localparam int unsigned IDX_W = $clog2(MAX_TASKS);
    localparam int unsigned CW    = $clog2(MAX_TASKS + 1);
    localparam int unsigned WW    = (CW > SLOT_W) ? CW : SLOT_W;

    // Control registers.
    fsm_t                state_reg, state_next;
    logic [CW-1:0]       used_reg, used_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [SLICE_W-1:0]  tick_reg, tick_next;
    logic [SLICE_W-1:0]  slice_reg;
    logic [IDX_W-1:0]    cand_reg, cand_next;
    logic [SLOT_W-1:0]   target_reg, target_next;
    logic                done_reg, done_next;

    // Result payload registers.
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic                switched_reg, switched_next;

    // Flag memory ports.
    logic                slot_dead_mem [MAX_TASKS];
    logic                rd_data_reg;
    logic [IDX_W-1:0]    mem_raddr;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic                mem_wdata;

    // Helpers for the datapath.
    logic [SLICE_W-1:0]  tick_inc;
    logic [IDX_W-1:0]    tgt_idx;
    logic [WW-1:0]       tgt_wide;
    logic [IDX_W-1:0]    cur_succ;
    logic [IDX_W-1:0]    cand_succ;
    logic                cand_last;
    logic                cfg_write;

    // Successor of a slot in round-robin order over the slots in use.
    function automatic logic [IDX_W-1:0] succ_of(
        input logic [IDX_W-1:0] x,
        input logic [CW-1:0]    used
    );
        logic [CW-1:0] sum;
        sum = CW'(x) + CW'(1);
        if (sum == used)
        begin
            return '0;
        end
        return IDX_W'(sum);
    endfunction

    // Slot number as shown on the result port, masked to its width.
    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] x);
        logic [WW-1:0] w;
        w = WW'(x);
        return w[SLOT_W-1:0];
    endfunction

    assign tick_inc  = tick_reg + SLICE_W'(1);
    assign tgt_wide  = WW'(target_slot);
    assign tgt_idx   = IDX_W'(tgt_wide);
    assign cur_succ  = succ_of(cur_reg, used_reg);
    assign cand_succ = succ_of(cand_reg, used_reg);
    assign cand_last = ((CW'(cand_reg) + CW'(1)) == used_reg);

    // Sequencer: next state, memory accesses and result.
    always_comb
    begin
        state_next    = state_reg;
        used_next     = used_reg;
        cur_next      = cur_reg;
        tick_next     = tick_reg;
        cand_next     = cand_reg;
        target_next   = target_reg;
        done_next     = 1'b0;
        status_next   = status_reg;
        slot_next     = slot_reg;
        switched_next = switched_reg;
        mem_raddr     = cand_reg;
        mem_we        = 1'b0;
        mem_waddr     = cand_reg;
        mem_wdata     = 1'b0;

        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    target_next   = target_slot;
                    status_next   = ST_OK;
                    switched_next = 1'b0;
                    case (cmd)
                        CMD_TICK:
                        begin
                            slot_next = to_slot(cur_reg);
                            if (used_reg == '0)
                            begin
                                done_next = 1'b1;
                            end
                            else if (tick_inc != slice_reg)
                            begin
                                tick_next = tick_inc;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                tick_next = '0;
                                if (CW'(cur_reg) >= used_reg)
                                begin
                                    status_next   = ST_FAULT;
                                    switched_next = 1'b1;
                                    done_next     = 1'b1;
                                end
                                else
                                begin
                                    mem_raddr  = cur_reg;
                                    state_next = FSM_T_CUR;
                                end
                            end
                        end
                        CMD_ADD:
                        begin
                            if (used_reg == '0)
                            begin
                                // Empty table: append slot zero at once.
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = 1'b0;
                                used_next = CW'(1);
                                slot_next = '0;
                                done_next = 1'b1;
                            end
                            else
                            begin
                                mem_raddr  = '0;
                                cand_next  = '0;
                                state_next = FSM_A_SCAN;
                            end
                        end
                        CMD_REMOVE:
                        begin
                            if (tgt_wide < WW'(used_reg))
                            begin
                                mem_raddr  = tgt_idx;
                                state_next = FSM_R_CHK;
                            end
                            else
                            begin
                                status_next = ST_REJECT;
                                slot_next   = target_slot;
                                done_next   = 1'b1;
                            end
                        end
                        default:
                        begin
                            status_next = ST_REJECT;
                            slot_next   = '0;
                            done_next   = 1'b1;
                        end
                    endcase
                end
            end

            // Flag of the current slot has arrived.
            FSM_T_CUR:
            begin
                if (rd_data_reg)
                begin
                    status_next   = ST_FAULT;
                    slot_next     = to_slot(cur_reg);
                    switched_next = 1'b1;
                    done_next     = 1'b1;
                    state_next    = FSM_IDLE;
                end
                else
                begin
                    mem_raddr  = cur_succ;
                    cand_next  = cur_succ;
                    state_next = FSM_T_SCAN;
                end
            end

            // Walk forward one slot a cycle; the current slot is live, so
            // the walk always ends.
            FSM_T_SCAN:
            begin
                if (!rd_data_reg)
                begin
                    cur_next      = cand_reg;
                    status_next   = ST_OK;
                    slot_next     = to_slot(cand_reg);
                    switched_next = 1'b1;
                    done_next     = 1'b1;
                    state_next    = FSM_IDLE;
                end
                else
                begin
                    mem_raddr = cand_succ;
                    cand_next = cand_succ;
                end
            end

            // Look for the lowest dead slot, else append if there is room, else reject.
            FSM_A_SCAN:
            begin
                if (rd_data_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = cand_reg;
                    mem_wdata   = 1'b0;
                    status_next = ST_OK;
                    slot_next   = to_slot(cand_reg);
                    done_next   = 1'b1;
                    state_next  = FSM_IDLE;
                end
                else if (cand_last)
                begin
                    if (used_reg != CW'(MAX_TASKS))
                    begin
                        mem_we      = 1'b1;
                        mem_waddr   = IDX_W'(used_reg);
                        mem_wdata   = 1'b0;
                        used_next   = used_reg + CW'(1);
                        status_next = ST_OK;
                        slot_next   = to_slot(IDX_W'(used_reg));
                    end
                    else
                    begin
                        status_next = ST_REJECT;
                        slot_next   = '0;
                    end
                    done_next  = 1'b1;
                    state_next = FSM_IDLE;
                end
                else
                begin
                    mem_raddr = cand_reg + IDX_W'(1);
                    cand_next = cand_reg + IDX_W'(1);
                end
            end

            // Flag of the slot to remove has arrived.
            FSM_R_CHK:
            begin
                if (!rd_data_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = IDX_W'(WW'(target_reg));
                    mem_wdata   = 1'b1;
                    status_next = ST_OK;
                end
                else
                begin
                    status_next = ST_REJECT;
                end
                slot_next  = target_reg;
                done_next  = 1'b1;
                state_next = FSM_IDLE;
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
            used_reg  <= '0;
            cur_reg   <= '0;
            tick_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            cur_reg   <= cur_next;
            tick_reg  <= tick_next;
            done_reg  <= done_next;
        end
    end

    // Payload and scan position.
    always_ff @(posedge clk)
    begin
        cand_reg     <= cand_next;
        target_reg   <= target_next;
        status_reg   <= status_next;
        slot_reg     <= slot_next;
        switched_reg <= switched_next;
    end

    // Flag memory, read data registered.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_dead_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= slot_dead_mem[mem_raddr];
    end

    // Configuration register.
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_reg <= SLICE_RESET;
        end
        else if (cfg_write && (paddr[2] == REG_SLICE))
        begin
            slice_reg <= pwdata[SLICE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_SLICE) ? {{(32 - SLICE_W){1'b0}}, slice_reg} : '0;
    assign pready = 1'b1;

    // Outputs.
    assign busy     = (state_reg != FSM_IDLE);
    assign done     = done_reg;
    assign status   = status_reg;
    assign slot     = slot_reg;
    assign switched = switched_reg;

    // A result is only shown once the sequencer is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while sequencer busy");

    // Every accepted request either finishes at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (done || busy))
        else $error("accepted request lost");

    // The fill count never exceeds the table size.
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(MAX_TASKS))
        else $error("slot count beyond table size");

    // The current slot stays inside the slots in use.
    a_cur_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != '0) |-> (CW'(cur_reg) < used_reg))
        else $error("current slot outside slots in use");

endmodule

`default_nettype wire

@@ verif/scheduler_checker.sv @@
`timescale 1ns / 100ps

module scheduler_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // Request channel
    input  wire logic                            start,
    input  wire logic                            busy,
    input  wire logic [rrtss_pkg::CMD_W-1:0]     cmd,
    input  wire logic [rrtss_pkg::SLOT_W-1:0]    target_slot,
    // Result channel
    input  wire logic                            done,
    input  wire logic [rrtss_pkg::STATUS_W-1:0]  status,
    input  wire logic [rrtss_pkg::SLOT_W-1:0]    slot,
    input  wire logic                            switched,
    // Configuration port
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic                            pready,
    input  wire logic [2:0]                      paddr,
    input  wire logic [31:0]                     pwdata,
    // Totals for the top level
    output int                                   n_errors,
    output int                                   n_pending
);
    import rrtss_pkg::*;

    localparam int unsigned TABLE_SIZE   = MAX_TASKS_DEF;
    localparam int          REPORT_LIMIT = 10;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic                switched;
    } sched_result_t;

    // Shadow copy of the scheduler state and its one register.
    logic [TABLE_SIZE-1:0] dead_flags;
    int unsigned           used_count;
    logic [SLOT_W-1:0]     cur_slot;
    logic [SLICE_W-1:0]    tick_ctr;
    logic [SLICE_W-1:0]    slice_len;

    // Results still owed by the block, oldest first.
    sched_result_t         owed_results_q[$];
    int                    err_count;

    // Apply one request to the shadow state and return the result it must give.
    function automatic sched_result_t schedule_request(input logic [CMD_W-1:0] c,
                                                       input logic [SLOT_W-1:0] t);
        sched_result_t r;
        int unsigned   idx;
        int unsigned   i;
        logic          found;
        r.status   = ST_OK;
        r.slot     = cur_slot;
        r.switched = 1'b0;
        found      = 1'b0;
        case (c)
            CMD_TICK:
            begin
                // Ticks only count while at least one slot is in use.
                if (used_count != 0)
                begin
                    tick_ctr = tick_ctr + 1'b1;
                    if (tick_ctr == slice_len)
                    begin
                        tick_ctr   = '0;
                        r.switched = 1'b1;
                        if (cur_slot >= used_count || dead_flags[cur_slot])
                        begin
                            r.status = ST_FAULT;
                        end
                        else
                        begin
                            // Next live slot after the current one, wrapping round.
                            for (i = 1; i <= used_count && !found; i++)
                            begin
                                idx = (cur_slot + i) % used_count;
                                if (!dead_flags[idx])
                                begin
                                    cur_slot = SLOT_W'(idx);
                                    found    = 1'b1;
                                end
                            end
                        end
                        r.slot = cur_slot;
                    end
                end
            end
            CMD_ADD:
            begin
                r.slot = '0;
                // Reuse the lowest dead slot, else append one if there is room.
                for (i = 0; i < used_count && !found; i++)
                begin
                    if (dead_flags[i])
                    begin
                        dead_flags[i] = 1'b0;
                        r.slot        = SLOT_W'(i);
                        found         = 1'b1;
                    end
                end
                if (!found)
                begin
                    if (used_count < TABLE_SIZE)
                    begin
                        dead_flags[used_count] = 1'b0;
                        r.slot                 = SLOT_W'(used_count);
                        used_count             = used_count + 1;
                    end
                    else
                    begin
                        r.status = ST_REJECT;
                    end
                end
            end
            CMD_REMOVE:
            begin
                r.slot = t;
                if (t < used_count && !dead_flags[t])
                begin
                    dead_flags[t] = 1'b1;
                end
                else
                begin
                    r.status = ST_REJECT;
                end
            end
            default:
            begin
                r.status = ST_REJECT;
                r.slot   = '0;
            end
        endcase
        return r;
    endfunction

    task automatic report_field(input string field, input logic [7:0] want,
                                input logic [7:0] got);
        err_count = err_count + 1;
        if (err_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    // Watch both channels and the register port at every rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t want;
        if (!rst_n)
        begin
            dead_flags = '0;
            used_count = 0;
            cur_slot   = '0;
            tick_ctr   = '0;
            slice_len  = SLICE_RESET;
            err_count  = 0;
            owed_results_q.delete();
            n_errors  <= 0;
            n_pending <= 0;
        end
        else
        begin
            // Compare a shown result with the oldest one owed.
            if (done)
            begin
                if (owed_results_q.size() == 0)
                begin
                    err_count = err_count + 1;
                    if (err_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: result shown with no request outstanding", $time);
                    end
                end
                else
                begin
                    want = owed_results_q.pop_front();
                    if (status !== want.status)
                    begin
                        report_field("status", 8'(want.status), 8'(status));
                    end
                    if (slot !== want.slot)
                    begin
                        report_field("slot", 8'(want.slot), 8'(slot));
                    end
                    if (switched !== want.switched)
                    begin
                        report_field("switched", 8'(want.switched), 8'(switched));
                    end
                end
            end

            // A request taken at this edge.
            if (start && !busy)
            begin
                owed_results_q.push_back(schedule_request(cmd, target_slot));
            end

            // Register write; other indexes are ignored by the block.
            if (psel && penable && pwrite && pready && paddr[2] == REG_SLICE)
            begin
                slice_len = pwdata[SLICE_W-1:0];
            end

            n_errors  <= err_count;
            n_pending <= owed_results_q.size();
        end
    end

endmodule

@@ verif/round_robin_task_slot_scheduler_unit_test.sv @@
`timescale 1ns / 100ps

module round_robin_task_slot_scheduler_unit_test;
    import rrtss_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED       = 2'd3;
    localparam logic             REG_UNUSED       = 1'b1;
    localparam int               PHASE_ITEMS      = 255;
    localparam int               ZERO_SLICE_TICKS = 32;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                start       = 1'b0;
    logic [CMD_W-1:0]    cmd         = CMD_TICK;
    logic [SLOT_W-1:0]   target_slot = '0;
    logic                psel        = 1'b0;
    logic                penable     = 1'b0;
    logic                pwrite      = 1'b0;
    logic [2:0]          paddr       = '0;
    logic [31:0]         pwdata      = '0;

    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic                switched;
    logic [31:0]         prdata;
    logic                pready;

    int                  n_errors;
    int                  n_pending;
    int                  idle_pct = 25;
    int                  n_added  = 0;

    round_robin_task_slot_scheduler_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .target_slot (target_slot),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .switched    (switched),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    scheduler_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .target_slot (target_slot),
        .done        (done),
        .status      (status),
        .slot        (slot),
        .switched    (switched),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .n_errors    (n_errors),
        .n_pending   (n_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard limit on the run, several times the slowest correct run.
    initial
    begin
        #8_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Offer one request, with random idle cycles first, and hold it until taken.
    task automatic send_request(input logic [CMD_W-1:0] c, input logic [SLOT_W-1:0] t);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start       <= 1'b0;
            cmd         <= CMD_W'($urandom_range(0, 3));
            target_slot <= SLOT_W'($urandom_range(0, 63));
            @(posedge clk);
        end
        start       <= 1'b1;
        cmd         <= c;
        target_slot <= t;
        if (c == CMD_ADD)
        begin
            n_added = n_added + 1;
        end
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
    endtask

    // Stop sending and wait until every owed result has been shown.
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (n_pending != 0 || busy)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // Register write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [SLICE_W-1:0] val);
        logic [15:0] junk;
        junk     = 16'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {junk, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // One random phase at a given slice length and mix of commands.
    task automatic run_phase(input logic [SLICE_W-1:0] len, input int add_pct, input int idle);
        logic [CMD_W-1:0]  c;
        logic [SLOT_W-1:0] t;
        int                roll;
        int                bound;
        drain();
        write_reg(REG_UNUSED, 16'($urandom));
        write_reg(REG_SLICE, len);
        idle_pct = idle;
        repeat (PHASE_ITEMS)
        begin
            if ($urandom_range(0, 99) < 2)
            begin
                drain();
            end
            roll = $urandom_range(0, 99);
            t    = SLOT_W'($urandom_range(0, 63));
            if (roll < 4)
            begin
                c = CMD_UNUSED;
            end
            else if (roll < 4 + add_pct)
            begin
                c = CMD_ADD;
            end
            else if (roll < 29 + add_pct)
            begin
                // Mostly aim removals at slots that may be in use.
                c     = CMD_REMOVE;
                bound = (n_added < 64) ? n_added : 64;
                if (bound > 0 && $urandom_range(0, 99) < 80)
                begin
                    t = SLOT_W'($urandom_range(0, bound - 1));
                end
            end
            else
            begin
                c = CMD_TICK;
            end
            send_request(c, t);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, unknown command, adds and rejected removals at reset slice length.
        send_request(CMD_TICK, 6'd63);
        send_request(CMD_UNUSED, 6'd5);
        send_request(CMD_REMOVE, 6'd0);
        send_request(CMD_ADD, 6'd0);
        send_request(CMD_ADD, 6'd63);
        send_request(CMD_ADD, 6'd0);
        send_request(CMD_REMOVE, 6'd63);

        // One-tick slices: wrap round three slots, then faults on a dead slot.
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        write_reg(REG_SLICE, 16'd1);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_REMOVE, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_REMOVE, 6'd0);
        send_request(CMD_ADD, 6'd0);
        send_request(CMD_REMOVE, 6'd1);
        send_request(CMD_REMOVE, 6'd2);
        send_request(CMD_TICK, 6'd0);
        send_request(CMD_ADD, 6'd0);

        // Random phases with rising slice lengths so the counter never overshoots.
        run_phase(16'd1, 20, 25);
        run_phase(16'd2, 15, 25);
        run_phase(16'd3, 25, 25);
        run_phase(16'd5, 45, 0);
        run_phase(16'd7, 30, 25);
        run_phase(16'hFFFF, 25, 25);

        // Zero slice length: the counter runs on without ending a slice.
        drain();
        write_reg(REG_SLICE, 16'd0);
        idle_pct = 0;
        repeat (ZERO_SLICE_TICKS)
        begin
            send_request(CMD_TICK, SLOT_W'($urandom));
        end

        drain();
        repeat (70) @(posedge clk);
        if (n_errors == 0 && n_pending == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
